>>> sv/htw_pkg.sv
// Package for the hashed timing wheel: shared opcodes, result kinds, wheel size
// limit and divider request/response types. No dependencies.
`default_nettype none
package htw_pkg;
    localparam int MAX_SLOTS = 256;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_REM   = 2'd1;
    localparam logic [1:0] KIND_FIRED = 2'd2;

    localparam logic CFG_SLOTS = 1'b0;
    localparam logic CFG_RES   = 1'b1;

    typedef struct packed {
        logic        start;
        logic [39:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [39:0] quot;
        logic [15:0] rem;
    } div_rsp_t;
endpackage
`default_nettype wire

>>> sv/hashed_timing_wheel_top.sv
// Top level of the hashed timing wheel: task table, sequencer, result register.
// Depends on htw_pkg and htw_div.
`default_nettype none
//  channel | ports                                   | direction
//  s_      | opcode repeating delay/repeat/target    | in, valid/ready
//  m_      | kind task_id ok last                    | out, valid/ready
//  cfg_    | wr_en index data                        | in, write only
//
// Add: one table scan plus two divider passes (delay/res, pos/slots) on the
// bit-serial divider. Remove: one table scan, one entry a cycle. Tick: per fired
// task, an oldest-first search, a look-ahead for last and, for repeating tasks,
// two divider passes; a cursor left beyond a shrunk slot count costs one more
// pass. Reset is synchronous; no clearing pass is needed. s_ready is low while
// an item is in work; a result waits in the output register while m_ready is
// low, and the sequencer waits with it.
module hashed_timing_wheel_top #(
    parameter int MAX_TASKS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic        s_repeating,
    input  wire logic [31:0] s_delay_time,
    input  wire logic [31:0] s_repeat_time,
    input  wire logic [31:0] s_target_id,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [31:0]      m_task_id,
    output logic             m_ok,
    output logic             m_last
);
    import htw_pkg::*;

    localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int SW = $clog2(MAX_SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_ADD_SCAN, S_DIV1, S_DIV2, S_REM_SCAN, S_TICK_SCAN,
        S_TICK_FIRE, S_OUT, S_RESCHED, S_ADVANCE, S_ADV_DIV
    } state_t;

    state_t state_reg;

    // config
    logic [8:0]  slot_count_reg;
    logic [15:0] tick_res_reg;

    // table
    logic [MAX_TASKS-1:0] valid_reg;
    logic [MAX_TASKS-1:0] fired_reg;
    logic [31:0] id_mem       [MAX_TASKS];
    logic [7:0]  slot_mem     [MAX_TASKS];
    logic [31:0] round_mem    [MAX_TASKS];
    logic [31:0] interval_mem [MAX_TASKS];
    logic [31:0] stamp_mem    [MAX_TASKS];

    logic [7:0]  cursor_reg;
    logic [31:0] wheel_round_reg;
    logic [31:0] next_id_reg;
    logic [31:0] next_stamp_reg;

    // working registers
    logic        rep_reg;
    logic [31:0] delay_reg;
    logic [31:0] rtime_reg;
    logic [31:0] target_reg;
    logic [TW:0] idx_reg;
    logic [TW-1:0] k_reg;
    logic        found_reg;
    logic [31:0] best_age_reg;
    logic [31:0] tick_stamp_reg;   // stamp counter at tick start, ages are frozen
    logic        any_fired_reg;
    logic        is_add_reg;
    logic        cont_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    htw_div u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));

    // effective configuration
    logic [SW-1:0] eff_slots;
    logic [15:0]   eff_res;
    always_comb begin
        if (slot_count_reg == 9'd0) eff_slots = SW'(1);
        else if (32'(slot_count_reg) > 32'(MAX_SLOTS)) eff_slots = SW'(MAX_SLOTS);
        else eff_slots = SW'(slot_count_reg);
        eff_res = (tick_res_reg == 16'd0) ? 16'd1 : tick_res_reg;
    end

    logic [TW-1:0] idx;
    assign idx = idx_reg[TW-1:0];
    logic scan_end;
    assign scan_end = (idx_reg == (TW+1)'(MAX_TASKS));

    logic due;
    assign due = valid_reg[idx] && !fired_reg[idx] && slot_mem[idx] == cursor_reg
                 && round_mem[idx] == wheel_round_reg;
    logic [31:0] age;
    assign age = tick_stamp_reg - stamp_mem[idx];

    logic [31:0] d_clamp;
    logic [31:0] r_clamp;
    assign d_clamp = (s_delay_time < 32'(eff_res)) ? 32'(eff_res) : s_delay_time;
    assign r_clamp = (s_repeat_time < 32'(eff_res)) ? 32'(eff_res) : s_repeat_time;

    assign s_ready = (state_reg == S_IDLE) && !m_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            slot_count_reg  <= 9'd64;
            tick_res_reg    <= 16'd1;
            valid_reg       <= '0;
            fired_reg       <= '0;
            cursor_reg      <= '0;
            wheel_round_reg <= '0;
            next_id_reg     <= 32'd1;
            next_stamp_reg  <= '0;
            m_valid         <= 1'b0;
            div_req.start   <= 1'b0;
        end else begin
            div_req.start <= 1'b0;
            if (cfg_wr_en) begin
                if (cfg_index == CFG_SLOTS) slot_count_reg <= cfg_data[8:0];
                else tick_res_reg <= cfg_data;
            end
            if (m_valid && m_ready) m_valid <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        rep_reg    <= s_repeating;
                        delay_reg  <= d_clamp;
                        rtime_reg  <= r_clamp;
                        target_reg <= s_target_id;
                        idx_reg    <= '0;
                        found_reg  <= 1'b0;
                        if (s_opcode == OP_ADD) state_reg <= S_ADD_SCAN;
                        else if (s_opcode == OP_REMOVE) state_reg <= S_REM_SCAN;
                        else if (s_opcode == OP_TICK) begin
                            fired_reg      <= '0;
                            any_fired_reg  <= 1'b0;
                            tick_stamp_reg <= next_stamp_reg;
                            state_reg      <= S_TICK_SCAN;
                        end
                    end
                end
                S_ADD_SCAN: begin
                    if (scan_end) begin
                        m_valid   <= 1'b1;
                        m_kind    <= KIND_ADD;
                        m_task_id <= 32'd0;
                        m_ok      <= 1'b0;
                        m_last    <= 1'b1;
                        state_reg <= S_OUT;
                        cont_reg  <= 1'b0;
                    end else if (!valid_reg[idx]) begin
                        k_reg              <= idx;
                        valid_reg[idx]     <= 1'b1;
                        id_mem[idx]        <= next_id_reg;
                        interval_mem[idx]  <= rep_reg ? rtime_reg : 32'd0;
                        is_add_reg         <= 1'b1;
                        div_req.start      <= 1'b1;
                        div_req.dividend   <= 40'(delay_reg);
                        div_req.divisor    <= eff_res;
                        state_reg          <= S_DIV1;
                    end else idx_reg <= idx_reg + (TW+1)'(1);
                end
                S_DIV1: begin
                    if (div_rsp.done) begin
                        div_req.start    <= 1'b1;
                        div_req.dividend <= div_rsp.quot + 40'(cursor_reg);
                        div_req.divisor  <= 16'(eff_slots);
                        state_reg        <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (div_rsp.done) begin
                        slot_mem[k_reg]  <= div_rsp.rem[7:0];
                        round_mem[k_reg] <= wheel_round_reg + div_rsp.quot[31:0];
                        stamp_mem[k_reg] <= next_stamp_reg;
                        next_stamp_reg   <= next_stamp_reg + 32'd1;
                        if (is_add_reg) begin
                            m_valid     <= 1'b1;
                            m_kind      <= KIND_ADD;
                            m_task_id   <= next_id_reg;
                            m_ok        <= 1'b1;
                            m_last      <= 1'b1;
                            next_id_reg <= next_id_reg + 32'd1;
                            cont_reg    <= 1'b0;
                            state_reg   <= S_OUT;
                        end else begin
                            idx_reg   <= '0;
                            found_reg <= 1'b0;
                            state_reg <= S_TICK_SCAN;
                        end
                    end
                end
                S_REM_SCAN: begin
                    if (scan_end || (valid_reg[idx] && id_mem[idx] == target_reg)) begin
                        if (!scan_end) valid_reg[idx] <= 1'b0;
                        m_valid   <= 1'b1;
                        m_kind    <= KIND_REM;
                        m_task_id <= target_reg;
                        m_ok      <= !scan_end;
                        m_last    <= 1'b1;
                        cont_reg  <= 1'b0;
                        state_reg <= S_OUT;
                    end else idx_reg <= idx_reg + (TW+1)'(1);
                end
                // Oldest due entry not yet fired this tick. Due set is frozen
                // by fired_reg; rescheduled entries never match the old round
                // and slot simultaneously unless placed into the same slot,
                // so they are also marked fired.
                S_TICK_SCAN: begin
                    if (scan_end) begin
                        if (found_reg) state_reg <= S_TICK_FIRE;
                        else if (any_fired_reg) state_reg <= S_ADVANCE;
                        else state_reg <= S_ADVANCE;
                    end else begin
                        if (due && (!found_reg || age > best_age_reg)) begin
                            found_reg    <= 1'b1;
                            best_age_reg <= age;
                            k_reg        <= idx;
                        end
                        idx_reg <= idx_reg + (TW+1)'(1);
                    end
                end
                S_TICK_FIRE: begin
                    // payload staged here, offered once last is known
                    fired_reg[k_reg] <= 1'b1;
                    any_fired_reg    <= 1'b1;
                    m_kind           <= KIND_FIRED;
                    m_task_id        <= id_mem[k_reg];
                    m_ok             <= 1'b1;
                    m_last           <= 1'b0;
                    idx_reg          <= '0;
                    found_reg        <= 1'b0;
                    cont_reg         <= 1'b1;
                    state_reg        <= S_OUT;
                end
                S_OUT: begin
                    // fired results: look ahead for another due entry, then
                    // settle last and offer the transaction
                    if (!cont_reg) begin
                        if (!m_valid || m_ready) state_reg <= S_IDLE;
                    end else if (!scan_end) begin
                        if (due && !(idx == k_reg)) found_reg <= 1'b1;
                        idx_reg <= idx_reg + (TW+1)'(1);
                    end else begin
                        if (!found_reg) m_last <= 1'b1;
                        m_valid   <= 1'b1;
                        state_reg <= S_RESCHED;
                    end
                end
                S_RESCHED: begin
                    if (!m_valid || m_ready) begin
                        if (interval_mem[k_reg] != 32'd0) begin
                            is_add_reg       <= 1'b0;
                            div_req.start    <= 1'b1;
                            div_req.dividend <= 40'(interval_mem[k_reg]);
                            div_req.divisor  <= eff_res;
                            state_reg        <= S_DIV1;
                        end else begin
                            valid_reg[k_reg] <= 1'b0;
                            idx_reg          <= '0;
                            found_reg        <= 1'b0;
                            state_reg        <= S_TICK_SCAN;
                        end
                    end
                end
                S_ADVANCE: begin
                    if (!m_valid || m_ready) begin
                        if (32'(cursor_reg) == 32'(eff_slots) - 32'd1)
                            wheel_round_reg <= wheel_round_reg + 32'd1;
                        if (32'(cursor_reg) + 32'd1 < 32'(eff_slots)) begin
                            cursor_reg <= cursor_reg + 8'd1;
                            state_reg  <= S_IDLE;
                        end else if (32'(cursor_reg) + 32'd1 == 32'(eff_slots)) begin
                            cursor_reg <= '0;
                            state_reg  <= S_IDLE;
                        end else begin
                            // cursor beyond a shrunk slot count: wrap by remainder
                            div_req.start    <= 1'b1;
                            div_req.dividend <= 40'(cursor_reg) + 40'd1;
                            div_req.divisor  <= 16'(eff_slots);
                            state_reg        <= S_ADV_DIV;
                        end
                    end
                end
                S_ADV_DIV: begin
                    if (div_rsp.done) begin
                        cursor_reg <= div_rsp.rem[7:0];
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> sv/htw_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on htw_pkg.
`default_nettype none
module htw_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire htw_pkg::div_req_t req,
    output htw_pkg::div_rsp_t      rsp
);
    import htw_pkg::*;

    logic [39:0] q_reg;
    logic [16:0] r_reg;
    logic [15:0] d_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [16:0] r_sh;
    logic [16:0] r_sub;

    assign r_sh  = {r_reg[15:0], q_reg[39]};
    assign r_sub = r_sh - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                q_reg    <= req.dividend;
                r_reg    <= '0;
                d_reg    <= req.divisor;
                cnt_reg  <= 6'd40;
            end else if (busy_reg) begin
                if (!r_sub[16]) begin
                    r_reg <= r_sub;
                    q_reg <= {q_reg[38:0], 1'b1};
                end else begin
                    r_reg <= r_sh;
                    q_reg <= {q_reg[38:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
    assign rsp.rem  = r_reg[15:0];
endmodule
`default_nettype wire

>>> tb/sv/htw_checker.sv
`timescale 1ns / 100ps
// Checker for the hashed timing wheel: mirrors the task table, predicts every result
// and compares the result channel against it. Depends on htw_pkg.
module htw_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic        s_repeating,
    input  wire logic [31:0] s_delay_time,
    input  wire logic [31:0] s_repeat_time,
    input  wire logic [31:0] s_target_id,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [1:0]  m_kind,
    input  wire logic [31:0] m_task_id,
    input  wire logic        m_ok,
    input  wire logic        m_last,
    output int               fail_count,
    output int               pending
);
    import htw_pkg::*;

    localparam int TASKS = 16;
    localparam int SLOTS_MAX = 256;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] id;
        logic        ok;
        logic        last;
    } wheel_result_t;

    wheel_result_t awaited_results[$];

    logic [8:0]  slot_cfg;
    logic [15:0] res_cfg;
    logic        tsk_valid [TASKS];
    logic [31:0] tsk_id [TASKS];
    logic [7:0]  tsk_slot [TASKS];
    logic [31:0] tsk_round [TASKS];
    logic [31:0] tsk_interval [TASKS];
    logic [31:0] tsk_stamp [TASKS];
    logic [31:0] cursor, round_now, id_next, stamp_next;
    int          fails;

    function automatic int unsigned wheel_slots(logic [8:0] s);
        if (s == 0) return 1;
        if (s > SLOTS_MAX) return SLOTS_MAX;
        return s;
    endfunction

    function automatic int unsigned wheel_res(logic [15:0] r);
        return (r == 0) ? 1 : r;
    endfunction

    task automatic schedule_task(int k, logic [31:0] dly);
        longint unsigned pos, slots;
        slots = wheel_slots(slot_cfg);
        pos = longint'(cursor) + longint'(dly / wheel_res(res_cfg));
        tsk_slot[k] = 8'(pos % slots);
        tsk_round[k] = round_now + 32'(pos / slots);
        tsk_stamp[k] = stamp_next;
        stamp_next = stamp_next + 1;
    endtask

    task automatic push_result(logic [1:0] kind, logic [31:0] id, logic ok, logic last);
        wheel_result_t r;
        r.kind = kind; r.id = id; r.ok = ok; r.last = last;
        awaited_results.insert(awaited_results.size(), r);
    endtask

    task automatic predict_op(logic [1:0] op, logic rep, logic [31:0] dly,
                              logic [31:0] rtm, logic [31:0] tgt);
        int k, best, n;
        logic [31:0] age, best_age, res;
        logic due [TASKS];
        int order [TASKS];
        k = -1;
        n = 0;
        res = wheel_res(res_cfg);
        case (op)
            OP_ADD: begin
                for (int i = 0; i < TASKS; i++)
                    if (!tsk_valid[i] && k < 0) k = i;
                if (k < 0) begin
                    push_result(KIND_ADD, 32'd0, 1'b0, 1'b1);
                end else begin
                    if (dly < res) dly = res;
                    if (rtm < res) rtm = res;
                    tsk_valid[k] = 1'b1;
                    tsk_id[k] = id_next;
                    tsk_interval[k] = rep ? rtm : 32'd0;
                    schedule_task(k, dly);
                    push_result(KIND_ADD, id_next, 1'b1, 1'b1);
                    id_next = id_next + 1;
                end
            end
            OP_REMOVE: begin
                for (int i = 0; i < TASKS; i++)
                    if (k < 0 && tsk_valid[i] && tsk_id[i] == tgt) k = i;
                if (k >= 0) tsk_valid[k] = 1'b0;
                push_result(KIND_REM, tgt, k >= 0, 1'b1);
            end
            OP_TICK: begin
                for (int i = 0; i < TASKS; i++)
                    due[i] = tsk_valid[i] && tsk_slot[i] == cursor && tsk_round[i] == round_now;
                // oldest insertion first, by wrapped age
                forever begin
                    best = -1;
                    best_age = 0;
                    for (int i = 0; i < TASKS; i++) begin
                        age = stamp_next - tsk_stamp[i];
                        if (due[i] && (best < 0 || age > best_age)) begin
                            best = i;
                            best_age = age;
                        end
                    end
                    if (best < 0) break;
                    due[best] = 1'b0;
                    order[n++] = best;
                end
                for (int i = 0; i < n; i++)
                    push_result(KIND_FIRED, tsk_id[order[i]], 1'b1, i == n - 1);
                for (int i = 0; i < n; i++) begin
                    if (tsk_interval[order[i]] > 0) schedule_task(order[i], tsk_interval[order[i]]);
                    else tsk_valid[order[i]] = 1'b0;
                end
                if (cursor == wheel_slots(slot_cfg) - 1) round_now = round_now + 1;
                cursor = (cursor + 1) % wheel_slots(slot_cfg);
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        wheel_result_t exp_r;
        if (!aresetn) begin
            slot_cfg = 9'd64;
            res_cfg = 16'd1;
            for (int i = 0; i < TASKS; i++) tsk_valid[i] = 1'b0;
            cursor = 0;
            round_now = 0;
            id_next = 1;
            stamp_next = 0;
            fails = 0;
            awaited_results.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_SLOTS) slot_cfg = cfg_data[8:0];
                else res_cfg = cfg_data;
            end
            if (s_valid && s_ready)
                predict_op(s_opcode, s_repeating, s_delay_time, s_repeat_time, s_target_id);
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result transaction: kind %0d id %0d", m_kind, m_task_id);
                    fails++;
                end else begin
                    exp_r = awaited_results.pop_front();
                    if (m_kind !== exp_r.kind) begin
                        $error("kind: expected %0d, got %0d", exp_r.kind, m_kind);
                        fails++;
                    end
                    if (m_task_id !== exp_r.id) begin
                        $error("task_id: expected %0d, got %0d", exp_r.id, m_task_id);
                        fails++;
                    end
                    if (m_ok !== exp_r.ok) begin
                        $error("ok: expected %0d, got %0d", exp_r.ok, m_ok);
                        fails++;
                    end
                    if (m_last !== exp_r.last) begin
                        $error("last: expected %0d, got %0d", exp_r.last, m_last);
                        fails++;
                    end
                end
            end
        end
        fail_count <= fails;
        pending <= awaited_results.size();
    end
endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for hashed_timing_wheel_top: clock, reset, stimulus and verdict.
// Depends on htw_pkg, htw_checker and the block itself.
module tb_top;
    import htw_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;   // not decoded by the block
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE = 4000;              // margin for the worst-case tick
    localparam int PHASE_ITEMS = 25;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        s_valid, s_ready;
    logic [1:0]  s_opcode;
    logic        s_repeating;
    logic [31:0] s_delay_time, s_repeat_time, s_target_id;
    logic        m_valid, m_ready;
    logic [1:0]  m_kind;
    logic [31:0] m_task_id;
    logic        m_ok, m_last;

    int fail_count, pending;
    int cycles = 0;
    int sent = 0;
    int adds_sent = 0;
    int burst_left = 0;
    int unsigned cur_res = 1;

    hashed_timing_wheel_top u_top (
        .aclk, .aresetn, .cfg_wr_en, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_opcode, .s_repeating, .s_delay_time,
        .s_repeat_time, .s_target_id,
        .m_valid, .m_ready, .m_kind, .m_task_id, .m_ok, .m_last
    );

    htw_checker u_checker (
        .aclk, .aresetn, .cfg_wr_en, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_opcode, .s_repeating, .s_delay_time,
        .s_repeat_time, .s_target_id,
        .m_valid, .m_ready, .m_kind, .m_task_id, .m_ok, .m_last,
        .fail_count, .pending
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // watchdog: any hang ends the run as a failure
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one transaction and hold it until taken. Bursts of random length,
    // then a random gap with valid low.
    task automatic offer_op(logic [1:0] op, logic rep, logic [31:0] dly,
                            logic [31:0] rtm, logic [31:0] tgt);
        s_valid       <= 1'b1;
        s_opcode      <= op;
        s_repeating   <= rep;
        s_delay_time  <= dly;
        s_repeat_time <= rtm;
        s_target_id   <= tgt;
        do @(posedge aclk); while (!s_ready);
        sent++;
        if (op == OP_ADD) adds_sent++;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(0, 15);
        end else begin
            burst_left--;
        end
    endtask

    // Let everything predicted come out, then cover ticks that give no result.
    task automatic drain_block();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Leaves the write enable high; the caller drops it after the last write.
    task automatic write_reg(logic idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        if (idx == CFG_RES) cur_res = (val == 0) ? 1 : val;
    endtask

    // Mostly short delays of up to twelve ticks so tasks actually fire; now and then
    // the full 32-bit range.
    function automatic logic [31:0] pick_time();
        if ($urandom_range(0, 99) < 85) return $urandom_range(0, 12 * cur_res);
        return $urandom;
    endfunction

    task automatic random_op();
        int unsigned sel;
        logic [31:0] tgt;
        sel = $urandom_range(0, 99);
        tgt = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, adds_sent + 2);
        if (sel < 42)      offer_op(OP_TICK, 1'($urandom), $urandom, $urandom, $urandom);
        else if (sel < 77) offer_op(OP_ADD, 1'($urandom), pick_time(), pick_time(), $urandom);
        else if (sel < 95) offer_op(OP_REMOVE, 1'($urandom), $urandom, $urandom, tgt);
        else               offer_op(OP_UNUSED, 1'($urandom), $urandom, $urandom, $urandom);
    endtask

    // Result side: random stall patterns, plus one long hold-off so the
    // output register and then the input side back up.
    initial begin
        bit held = 1'b0;
        m_ready = 1'b0;
        forever begin
            if (!held && sent >= 60) begin
                m_ready <= 1'b0;
                repeat (3000) @(posedge aclk);
                held = 1'b1;
            end else if ($urandom_range(0, 2) == 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(10, 60)) @(posedge aclk);
            end else begin
                repeat ($urandom_range(5, 40)) begin
                    m_ready <= ($urandom_range(0, 99) < 60);
                    @(posedge aclk);
                end
            end
        end
    end

    initial begin
        logic [8:0]  slot_set [6] = '{9'd1, 9'd0, 9'd256, 9'd511, 9'd5, 9'd200};
        logic [15:0] res_set  [6] = '{16'd1, 16'd0, 16'd65535, 16'd7, 16'd3, 16'd2};
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_SLOTS;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_opcode      = OP_TICK;
        s_repeating   = 1'b0;
        s_delay_time  = '0;
        s_repeat_time = '0;
        s_target_id   = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: clamps, extremes, remove hit and miss, ignored opcode,
        // empty tick, then fill the table to hit the full case
        offer_op(OP_ADD, 1'b1, 32'd0, 32'd0, 32'd0);
        offer_op(OP_ADD, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_op(OP_ADD, 1'b1, 32'd3, 32'd2, 32'd0);
        offer_op(OP_REMOVE, 1'b0, 32'd0, 32'd0, 32'd2);
        offer_op(OP_REMOVE, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_op(OP_UNUSED, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        repeat (5) offer_op(OP_TICK, 1'b0, 32'd0, 32'd0, 32'd0);
        repeat (15) offer_op(OP_ADD, 1'b0, 32'd2, 32'd0, 32'd0);
        repeat (3) offer_op(OP_TICK, 1'b0, 32'd0, 32'd0, 32'd0);
        drain_block();

        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_SLOTS, {7'd0, slot_set[p]});
            write_reg(CFG_RES, res_set[p]);
            cfg_wr_en <= 1'b0;
            repeat (PHASE_ITEMS) random_op();
            drain_block();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

>>> sim.f
sv/htw_pkg.sv
sv/htw_div.sv
sv/hashed_timing_wheel_top.sv
tb/sv/htw_checker.sv
tb/sv/tb_top.sv
